/* sv/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int WORD_W  = 32;
  localparam int ECNT_W  = 5;

  typedef enum logic [1:0] {
    FN_PUSH_BACK  = 2'd0,
    FN_PUSH_FRONT = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    func_t                     func;
    logic signed [WORD_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  pop_value;
    status_t                   status;
    logic [ECNT_W-1:0]         entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_RESULT = 2'd2
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* sv/deq_ctrl.sv */
// Controller state machine for the double-ended queue.
module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::sts_t sts,
  output deq_pkg::cmd_t cmd
);
  import deq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // wait for the output register to drain
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/deq_dp.sv */
// Datapath: ring store, front index, count and the output register.
module deq_dp (
  input  logic          clk,
  input  logic          rst,
  input  deq_pkg::req_t req,
  input  deq_pkg::cmd_t cmd,
  output deq_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  func_t             op;
  logic [WORD_W-1:0] value;
  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  status_t           pend_status, status_next;
  logic [CNT_W-1:0]  pend_count;

  logic              full, empty, is_pop;
  logic              we, re;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  front_dec, front_inc;
  logic [SUM_W-1:0]  sum_back, sum_last;
  logic [IDX_W-1:0]  pos_back, pos_last;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign is_pop = (op == FN_POP_FRONT) || (op == FN_POP_BACK);

  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
  assign front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + IDX_W'(1);

  // front + count, and front + count - 1 on a non-empty queue, stay below twice the depth
  assign sum_back = SUM_W'(front) + SUM_W'(count);
  assign sum_last = sum_back - SUM_W'(1);
  assign pos_back = (sum_back >= SUM_W'(DEPTH)) ? IDX_W'(sum_back - SUM_W'(DEPTH))
                                                : IDX_W'(sum_back);
  assign pos_last = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                : IDX_W'(sum_last);

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = ST_DONE;
    we          = 1'b0;
    re          = 1'b0;
    addr        = front;
    unique case (op)
      FN_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we         = 1'b1;
          addr       = pos_back;
          count_next = count + CNT_W'(1);
        end
      end
      FN_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we         = 1'b1;
          addr       = front_dec;
          front_next = front_dec;
          count_next = count + CNT_W'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          re         = 1'b1;
          addr       = front;
          front_next = front_inc;
          count_next = count - CNT_W'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          re         = 1'b1;
          addr       = pos_last;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && re) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op    <= req.func;
      value <= req.push_value;
    end
    if (cmd.exec) begin
      pend_status <= status_next;
      pend_count  <= count_next;
    end
    if (cmd.load) begin
      rsp.pop_value   <= (is_pop && pend_status == ST_DONE) ? rd_data : '0;
      rsp.status      <= pend_status;
      rsp.entry_count <= ECNT_W'(pend_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        front <= front_next;
        count <= count_next;
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !rsp_valid || !rsp_stall;

endmodule

/* sv/double_ended_queue.sv */
// Top level of the double-ended queue.
//
//   channel  dir  handshake               beat
//   req      in   req_valid / req_stall   func, push_value
//   rsp      out  rsp_valid / rsp_stall   pop_value, status, entry_count
//
// Each beat passes through three steps: latch, ring update with one store access,
// then load of the output register; the single store port sets this.
// A new req beat is taken while an earlier rsp beat still waits.
// rst clears the front index, the count and rsp_valid; the store is not cleared.
// A stalled rsp holds the next result in its result state until the register drains.
module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* verif/double_ended_queue_tb.sv */
// Self-checking testbench for the double-ended queue: directed and random beats.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int MAX_REPORTS = 10;

  logic  clk;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  // Shadow copy of the queue contents
  logic signed [WORD_W-1:0] shadow_ring [DEPTH];
  int shadow_front = 0;
  int shadow_count = 0;

  rsp_t pending_results [$];
  int   mismatches   = 0;
  int   cycle_count  = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left    = 0;

  double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** double_ended_queue: FAILED **");
      $finish;
    end
  end

  // Applies one operation to the shadow queue and returns the result it gives.
  function automatic rsp_t apply_deq_op(input req_t beat);
    rsp_t res;
    int   slot;
    res.pop_value = '0;
    res.status    = ST_DONE;
    case (beat.func)
      FN_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = (shadow_front + shadow_count) % DEPTH;
          shadow_ring[slot] = beat.push_value;
          shadow_count++;
        end
      end
      FN_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = beat.push_value;
          shadow_count++;
        end
      end
      FN_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (shadow_front + shadow_count - 1) % DEPTH;
          res.pop_value = shadow_ring[slot];
          shadow_count--;
        end
      end
    endcase
    res.entry_count = ECNT_W'(shadow_count);
    return res;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected rsp beat: pop_value=%0d status=%0d count=%0d",
                   $realtime, rsp.pop_value, rsp.status, rsp.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (rsp.pop_value !== want.pop_value || rsp.status !== want.status ||
            rsp.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] rsp mismatch: pop_value exp %0d got %0d,",
                     $realtime, want.pop_value, rsp.pop_value,
                     " status exp %0d got %0d, count exp %0d got %0d",
                     want.status, rsp.status, want.entry_count, rsp.entry_count);
        end
      end
    end
  end

  // Offers one beat after an optional random gap and waits for it to be taken.
  task automatic send_deq_op(input func_t fn, input logic signed [WORD_W-1:0] val);
    req_t beat;
    beat.func       = fn;
    beat.push_value = val;
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      req.push_value <= $urandom;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(apply_deq_op(beat));
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_pops();
    send_deq_op(FN_POP_FRONT, 32'sd5);
    send_deq_op(FN_POP_BACK, -32'sd5);
  endtask

  // Alternating ends makes the front index wrap below zero; then push while full.
  task automatic test_fill_past_full();
    logic signed [WORD_W-1:0] extremes [4];
    extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1};
    for (int i = 0; i < DEPTH; i++)
      send_deq_op((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK,
                  (i < 8) ? extremes[i % 4] : $urandom);
    send_deq_op(FN_PUSH_BACK, $urandom);
    send_deq_op(FN_PUSH_FRONT, $urandom);
  endtask

  task automatic test_both_end_pops();
    send_deq_op(FN_POP_FRONT, $urandom);
    send_deq_op(FN_POP_BACK, $urandom);
  endtask

  // Random traffic in runs biased toward pushes, pops or neither, so the
  // queue swings between empty and full.
  task automatic test_random_traffic(input int n_items, input int gap_pct, input int stall_pct);
    int    push_pct;
    func_t fn;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    push_pct       = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < push_pct)
        fn = $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
      else
        fn = $urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK;
      send_deq_op(fn, pick_word());
    end
    wait_for_drain();
  endtask

  // Receiver holds off while the sender keeps offering beats, so req_stall rises.
  task automatic test_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = 150;
    for (int i = 0; i < 30; i++)
      send_deq_op(func_t'($urandom_range(3)), pick_word());
    wait_for_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_pops();
    test_fill_past_full();
    test_both_end_pops();
    wait_for_drain();

    test_random_traffic(200, 23, 79);
    test_random_traffic(200, 79, 23);
    test_random_traffic(200, 0, 0);
    test_backpressure();

    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      mismatches++;
    if (mismatches == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_dp.sv
sv/double_ended_queue.sv
verif/double_ended_queue_tb.sv
